### design/mxbh_pkg.sv
// ----------------------------------------------------------------------------
// mxbh_pkg
// Shared types, seeds and the per-round micro-op table of the block hash.
// ----------------------------------------------------------------------------
package mxbh_pkg;

  typedef struct packed {
    logic [63:0] block_word_0;
    logic [63:0] block_word_1;
    logic [63:0] block_word_2;
    logic [63:0] block_word_3;
    logic        start_message;
    logic        last_block;
  } mxbh_in_t;

  typedef struct packed {
    logic [63:0] digest_first;
    logic [63:0] digest_second;
    logic [63:0] digest_third;
    logic [63:0] digest_fourth;
  } mxbh_out_t;

  localparam logic [63:0] SEED_ONE   = 64'ha7af31539e9190e7;
  localparam logic [63:0] SEED_TWO   = 64'ha293a5cc7f4400c8;
  localparam logic [63:0] SEED_THREE = 64'h26458d663397c103;
  localparam logic [63:0] SEED_FOUR  = 64'h99745a5c13c1216d;

  localparam logic [2:0] ROUND_LAST = 3'd7;
  localparam logic [4:0] UOP_LAST   = 5'd23;

  // micro-op kinds, one multiply each
  typedef enum logic [2:0] {
    UOP_MA_PROD,   // tmp = cross(src, dst) * src
    UOP_MA_APPLY,  // dst = dst * (tmp + 1)
    UOP_MB,        // dst = dst * (cross(src, dst) + 1)
    UOP_MC_FIRST,  // tmp = w1 * w2
    UOP_MC_MID,    // tmp = tmp * w3
    UOP_MC_LAST    // dst = dst ^ (tmp * w4 + 1)
  } uop_kind_t;

  // left shift of the cross term; the right shift is its complement to 64
  typedef enum logic [1:0] {
    SH_16,
    SH_32,
    SH_48
  } shift_sel_t;

  typedef struct packed {
    uop_kind_t  kind;
    logic [1:0] src;
    logic [1:0] dst;
    shift_sel_t sh;
  } uop_t;

  function automatic uop_t mk_uop(uop_kind_t kind, logic [1:0] src, logic [1:0] dst,
                                  shift_sel_t sh);
    uop_t u;
    u.kind = kind;
    u.src  = src;
    u.dst  = dst;
    u.sh   = sh;
    return u;
  endfunction

  function automatic logic [63:0] cross_mix(logic [63:0] hi_src, logic [63:0] lo_src,
                                            shift_sel_t sh);
    logic [63:0] r;
    case (sh)
      SH_16:   r = (hi_src << 16) ^ (lo_src >> 48);
      SH_48:   r = (hi_src << 48) ^ (lo_src >> 16);
      default: r = (hi_src << 32) ^ (lo_src >> 32);
    endcase
    return r;
  endfunction

  // one round: four steps of box a, four of box b, four of box c
  function automatic uop_t uop_lookup(logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = mk_uop(UOP_MA_PROD,  2'd0, 2'd3, SH_32);
      5'd1:    u = mk_uop(UOP_MA_APPLY, 2'd0, 2'd3, SH_32);
      5'd2:    u = mk_uop(UOP_MA_PROD,  2'd1, 2'd2, SH_48);
      5'd3:    u = mk_uop(UOP_MA_APPLY, 2'd1, 2'd2, SH_48);
      5'd4:    u = mk_uop(UOP_MA_PROD,  2'd2, 2'd1, SH_32);
      5'd5:    u = mk_uop(UOP_MA_APPLY, 2'd2, 2'd1, SH_32);
      5'd6:    u = mk_uop(UOP_MA_PROD,  2'd3, 2'd0, SH_16);
      5'd7:    u = mk_uop(UOP_MA_APPLY, 2'd3, 2'd0, SH_16);
      5'd8:    u = mk_uop(UOP_MB,       2'd0, 2'd3, SH_32);
      5'd9:    u = mk_uop(UOP_MB,       2'd1, 2'd2, SH_32);
      5'd10:   u = mk_uop(UOP_MB,       2'd2, 2'd1, SH_32);
      5'd11:   u = mk_uop(UOP_MB,       2'd3, 2'd0, SH_32);
      5'd12:   u = mk_uop(UOP_MC_FIRST, 2'd0, 2'd0, SH_32);
      5'd13:   u = mk_uop(UOP_MC_MID,   2'd0, 2'd0, SH_32);
      5'd14:   u = mk_uop(UOP_MC_LAST,  2'd0, 2'd0, SH_32);
      5'd15:   u = mk_uop(UOP_MC_FIRST, 2'd0, 2'd1, SH_32);
      5'd16:   u = mk_uop(UOP_MC_MID,   2'd0, 2'd1, SH_32);
      5'd17:   u = mk_uop(UOP_MC_LAST,  2'd0, 2'd1, SH_32);
      5'd18:   u = mk_uop(UOP_MC_FIRST, 2'd0, 2'd2, SH_32);
      5'd19:   u = mk_uop(UOP_MC_MID,   2'd0, 2'd2, SH_32);
      5'd20:   u = mk_uop(UOP_MC_LAST,  2'd0, 2'd2, SH_32);
      5'd21:   u = mk_uop(UOP_MC_FIRST, 2'd0, 2'd3, SH_32);
      5'd22:   u = mk_uop(UOP_MC_MID,   2'd0, 2'd3, SH_32);
      5'd23:   u = mk_uop(UOP_MC_LAST,  2'd0, 2'd3, SH_32);
      default: u = mk_uop(UOP_MB,       2'd0, 2'd0, SH_32);
    endcase
    return u;
  endfunction

endpackage

### design/mxbh_mul.sv
// ----------------------------------------------------------------------------
// mxbh_mul
// 64 x 64 multiply modulo 2^64 through one 32 x 32 multiplier in three passes.
// ----------------------------------------------------------------------------
module mxbh_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] pp_r, pp_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        active_r, active_nxt;
  logic        done_r, done_nxt;
  logic [31:0] op_a, op_b;
  logic [63:0] mult;

  // partial product select: low x low, low x high, high x low
  always_comb begin
    case (phase_r)
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      2'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
    endcase
  end

  assign mult = {32'd0, op_a} * {32'd0, op_b};

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    pp_nxt     = pp_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    phase_nxt  = phase_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      a_nxt      = a;
      b_nxt      = b;
      phase_nxt  = 2'd0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      case (phase_r)
        2'd0: begin
          pp_nxt    = mult;
          phase_nxt = 2'd1;
        end
        2'd1: begin
          acc_nxt   = pp_r;
          pp_nxt    = mult;
          phase_nxt = 2'd2;
        end
        2'd2: begin
          acc_nxt   = acc_r + {pp_r[31:0], 32'd0};
          pp_nxt    = mult;
          phase_nxt = 2'd3;
        end
        default: begin
          prod_nxt   = acc_r + {pp_r[31:0], 32'd0};
          done_nxt   = 1'b1;
          active_nxt = 1'b0;
          phase_nxt  = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    pp_r   <= pp_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (!rst_n) begin
      phase_r  <= 2'd0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

### design/multiply_xor_block_hash_256_core.sv
// ----------------------------------------------------------------------------
// multiply_xor_block_hash_256_core
// 256-bit multiply / shift / xor block hash: absorbs one 32-byte block per
// transfer into four 64-bit chaining words, emits them on the last block.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | carries
//  --------+--------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data    | four block words, start and last
//  output  | out_valid, out_ready, out_data | four digest words, last block only
//
//  a block runs from its transfer through 8 rounds of (a byte-xor step +
//  24 multiplies), then the finish state and the idle state that takes the
//  next block; each 64-bit product takes three passes through the single
//  32x32 multiplier in mxbh_mul. in_ready is high only while idle.
//  rst_n (synchronous) reloads the chaining words with the seeds.
//  a digest still waiting on out_ready does not block the next block; only
//  the finish of a following last block waits for the output register
//
module multiply_xor_block_hash_256_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mxbh_pkg::mxbh_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mxbh_pkg::mxbh_out_t  out_data
);

  import mxbh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        round_r, round_nxt;
  logic [4:0]        uop_idx_r, uop_idx_nxt;
  logic [3:0][63:0]  chain_r, chain_nxt;
  logic [255:0]      block_r, block_nxt;
  logic              last_r, last_nxt;
  logic [63:0]       tmp_r, tmp_nxt;
  logic              out_valid_r, out_valid_nxt;
  mxbh_out_t         out_data_r, out_data_nxt;

  uop_t              uop;
  logic [63:0]       src_w;
  logic [63:0]       dst_w;
  logic [31:0]       lane_bytes;
  logic              mul_start;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic              mul_done;
  logic [63:0]       mul_prod;

  // current micro-op and its chaining-word operands
  assign uop   = uop_lookup(uop_idx_r);
  assign src_w = chain_r[uop.src];
  assign dst_w = chain_r[uop.dst];

  // round j takes bytes 28-4j .. 31-4j, i.e. 32-bit lane 7-j of the block
  assign lane_bytes = block_r[{~round_r, 5'd0} +: 32];

  mxbh_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    uop_idx_nxt   = uop_idx_r;
    chain_nxt     = chain_r;
    block_nxt     = block_r;
    last_nxt      = last_r;
    tmp_nxt       = tmp_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mul_start     = 1'b0;
    mul_a         = dst_w;
    mul_b         = tmp_r + 64'd1;

    // digest leaves on the output transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          block_nxt   = {in_data.block_word_3, in_data.block_word_2,
                         in_data.block_word_1, in_data.block_word_0};
          last_nxt    = in_data.last_block;
          round_nxt   = 3'd0;
          uop_idx_nxt = 5'd0;
          if (in_data.start_message) begin
            chain_nxt[0] = SEED_ONE;
            chain_nxt[1] = SEED_TWO;
            chain_nxt[2] = SEED_THREE;
            chain_nxt[3] = SEED_FOUR;
          end
          state_nxt = ST_ABSORB;
        end
      end

      // xor one byte into each chaining word at byte position j
      ST_ABSORB: begin
        for (int k = 0; k < 4; k++) begin
          chain_nxt[k] = chain_r[k] ^ ({56'd0, lane_bytes[8*k +: 8]} << {round_r, 3'd0});
        end
        state_nxt = ST_ISSUE;
      end

      // pick operands for this micro-op and kick the multiplier
      ST_ISSUE: begin
        mul_start = 1'b1;
        case (uop.kind)
          UOP_MA_PROD: begin
            mul_a = cross_mix(src_w, dst_w, uop.sh);
            mul_b = src_w;
          end
          UOP_MA_APPLY: begin
            mul_a = dst_w;
            mul_b = tmp_r + 64'd1;
          end
          UOP_MB: begin
            mul_a = dst_w;
            mul_b = cross_mix(src_w, dst_w, SH_32) + 64'd1;
          end
          UOP_MC_FIRST: begin
            mul_a = chain_r[0];
            mul_b = chain_r[1];
          end
          UOP_MC_MID: begin
            mul_a = tmp_r;
            mul_b = chain_r[2];
          end
          UOP_MC_LAST: begin
            mul_a = tmp_r;
            mul_b = chain_r[3];
          end
          default: begin
            mul_a = dst_w;
            mul_b = tmp_r + 64'd1;
          end
        endcase
        state_nxt = ST_WAIT;
      end

      // write the product back and step the sequencer
      ST_WAIT: begin
        if (mul_done) begin
          case (uop.kind)
            UOP_MA_PROD, UOP_MC_FIRST, UOP_MC_MID: tmp_nxt = mul_prod;
            UOP_MA_APPLY, UOP_MB:                  chain_nxt[uop.dst] = mul_prod;
            UOP_MC_LAST: chain_nxt[uop.dst] = dst_w ^ (mul_prod + 64'd1);
            default:     tmp_nxt = tmp_r;
          endcase
          if (uop_idx_r == UOP_LAST) begin
            uop_idx_nxt = 5'd0;
            if (round_r == ROUND_LAST) begin
              state_nxt = ST_FINISH;
            end else begin
              round_nxt = round_r + 3'd1;
              state_nxt = ST_ABSORB;
            end
          end else begin
            uop_idx_nxt = uop_idx_r + 5'd1;
            state_nxt   = ST_ISSUE;
          end
        end
      end

      // hand the digest of a last block to the output register once it is free; other blocks return to idle
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.digest_first  = chain_r[0];
          out_data_nxt.digest_second = chain_r[1];
          out_data_nxt.digest_third  = chain_r[2];
          out_data_nxt.digest_fourth = chain_r[3];
          state_nxt                  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    block_r    <= block_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= 3'd0;
      uop_idx_r   <= 5'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= SEED_ONE;
      chain_r[1]  <= SEED_TWO;
      chain_r[2]  <= SEED_THREE;
      chain_r[3]  <= SEED_FOUR;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      uop_idx_r   <= uop_idx_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // multiplier results only come back while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_WAIT)
    else $error("multiplier done outside wait state");

  // an input transfer starts round zero at the first micro-op
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_ABSORB && round_r == 3'd0 && uop_idx_r == 5'd0)
    else $error("input transfer did not start absorbing");

  // byte xor happens only at the head of a round
  a_absorb_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ABSORB |-> uop_idx_r == 5'd0)
    else $error("absorb in mid round");

  // a new digest appears only from the finish of a last block
  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH && last_r))
    else $error("digest raised outside finish of a last block");

endmodule
